[design/tspf_pkg.sv]
`default_nettype none
package tspf_pkg;

    localparam int ADDR_W = 14;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [ADDR_W-1:0] NAMETABLE_BASE = 14'h2000;
    localparam logic [ADDR_W-1:0] ATTRIBUTE_BASE = 14'h23C0;
    localparam logic [ADDR_W-1:0] PALETTE_BASE   = 14'h3F00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NT,
        ST_AT,
        ST_LO,
        ST_HI,
        ST_HI_WAIT,
        ST_PIX
    } fetch_state_t;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_data;
        logic [4:0]        tile_column;
        logic [7:0]        pixel_row;
    } in_item_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } vram_req_t;

    // Pixel whose palette byte is being read this cycle.
    typedef struct packed {
        logic       valid;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [1:0] pixel_value;
        logic [1:0] palette_select;
        logic       last;
    } pend_t;

    typedef struct packed {
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [1:0] pixel_value;
        logic [1:0] palette_select;
        logic [7:0] color_index;
        logic       last;
    } pix_t;

endpackage
`default_nettype wire

[design/tspf_vram.sv]
`default_nettype none
module tspf_vram #(
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[design/tspf_fetch.sv]
`default_nettype none
module tspf_fetch
    import tspf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    input  wire logic      pattern_half,
    input  wire logic      issue_ok,
    input  wire logic [7:0] rdata,
    output vram_req_t      req,
    output pend_t          pend
);

    fetch_state_t state_reg, state_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [7:0]   low_reg, low_next;
    logic [7:0]   high_reg, high_next;
    logic [1:0]   pal_reg, pal_next;
    pend_t        pend_reg, pend_next;
    logic [4:0]   col_reg, col_next;
    logic [7:0]   row_reg, row_next;
    logic [7:0]   tile_reg, tile_next;

    logic              accept;
    logic [2:0]        bit_idx;
    logic [1:0]        value;
    logic [1:0]        attr_pal;
    logic [ADDR_W-1:0] nt_addr;
    logic [ADDR_W-1:0] at_addr;
    logic [ADDR_W-1:0] lo_addr;
    logic [ADDR_W-1:0] hi_addr;

    assign accept   = in_valid && in_ready;
    assign bit_idx  = ~cnt_reg;
    assign value    = {high_reg[bit_idx], low_reg[bit_idx]};
    // The quadrant picks one of the four two-bit fields of the attribute byte.
    assign attr_pal = 2'(rdata >> {row_reg[4], col_reg[1], 1'b0});
    assign nt_addr  = NAMETABLE_BASE | {4'b0, row_reg[7:3], col_reg};
    assign at_addr  = ATTRIBUTE_BASE | {8'b0, row_reg[7:5], col_reg[4:2]};
    assign lo_addr  = {1'b0, pattern_half, tile_reg, 1'b0, row_reg[2:0]};
    assign hi_addr  = {1'b0, pattern_half, tile_reg, 1'b1, row_reg[2:0]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_item.op == OP_RENDER)
                begin
                    state_next = ST_NT;
                end
            end
            ST_NT:      state_next = ST_AT;
            ST_AT:      state_next = ST_LO;
            ST_LO:      state_next = ST_HI;
            ST_HI:      state_next = ST_HI_WAIT;
            ST_HI_WAIT: state_next = ST_PIX;
            ST_PIX:
            begin
                if (issue_ok && cnt_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        req       = '0;
        cnt_next  = cnt_reg;
        low_next  = low_reg;
        high_next = high_reg;
        pal_next  = pal_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        tile_next = tile_reg;
        pend_next = pend_reg;
        pend_next.valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept && in_item.op == OP_WRITE)
                begin
                    req.en    = 1'b1;
                    req.we    = 1'b1;
                    req.addr  = in_item.write_address;
                    req.wdata = in_item.write_data;
                end
                col_next = in_item.tile_column;
                row_next = in_item.pixel_row;
                cnt_next = 3'd0;
            end
            ST_NT:
            begin
                req.en   = 1'b1;
                req.addr = nt_addr;
            end
            ST_AT:
            begin
                req.en    = 1'b1;
                req.addr  = at_addr;
                tile_next = rdata;
            end
            ST_LO:
            begin
                req.en   = 1'b1;
                req.addr = lo_addr;
                pal_next = attr_pal;
            end
            ST_HI:
            begin
                req.en   = 1'b1;
                req.addr = hi_addr;
                low_next = rdata;
            end
            ST_HI_WAIT:
            begin
                high_next = rdata;
            end
            ST_PIX:
            begin
                if (issue_ok)
                begin
                    req.en   = 1'b1;
                    req.addr = PALETTE_BASE | {10'b0, pal_reg, value};
                    pend_next.valid          = 1'b1;
                    pend_next.pixel_x        = {col_reg, cnt_reg};
                    pend_next.pixel_y        = row_reg;
                    pend_next.pixel_value    = value;
                    pend_next.palette_select = pal_reg;
                    pend_next.last           = (cnt_reg == 3'd7);
                    cnt_next                 = cnt_reg + 3'd1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
            low_reg   <= 8'd0;
            high_reg  <= 8'd0;
            pal_reg   <= 2'd0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            pal_reg   <= pal_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        row_reg  <= row_next;
        tile_reg <= tile_next;
    end

    assign pend = pend_reg;

    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |-> state_reg == ST_IDLE)
        else $error("memory write outside idle state");

    a_pend_from_pix: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg.valid |-> $past(state_reg) == ST_PIX)
        else $error("palette read in flight without pixel issue");

endmodule
`default_nettype wire

[design/tile_sliver_pixel_fetch_core.sv]
// Write item: stored in the cycle it is accepted.
// Render item: pixels come out one per cycle unless the output stalls; a new item
// is taken only once the render item has issued its last read, since the four serial fetches
// and eight palette reads share the single video memory port.
// Reset clears control state and sets the pattern half to 1; video memory is not
// cleared and holds no defined contents until written.
`default_nettype none
module tile_sliver_pixel_fetch_core
    import tspf_pkg::*;
#(
    parameter int VRAM_DEPTH = 16384
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // write_address[13:0], write_data[21:14], tile_column[26:22], pixel_row[34:27]
    input  wire logic [39:0] s_tdata,
    // op[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_x[7:0], pixel_y[15:8], pixel_value[17:16], palette_select[19:18],
    // color_index[27:20]
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_data
);

    localparam int AW = $clog2(VRAM_DEPTH);

    in_item_t   in_item;
    vram_req_t  req;
    pend_t      pend;
    logic [7:0] rdata;
    logic       issue_ok;
    logic       pop;
    pix_t       new_pix;

    logic       half_reg;
    logic [1:0] count_reg, count_next;
    pix_t       out_reg, out_next;
    pix_t       skid_reg, skid_next;

    assign in_item.op            = s_tuser[0];
    assign in_item.write_address = s_tdata[13:0];
    assign in_item.write_data    = s_tdata[21:14];
    assign in_item.tile_column   = s_tdata[26:22];
    assign in_item.pixel_row     = s_tdata[34:27];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_reg <= cfg_data[0];
        end
    end

    tspf_fetch u_fetch (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_item      (in_item),
        .pattern_half (half_reg),
        .issue_ok     (issue_ok),
        .rdata        (rdata),
        .req          (req),
        .pend         (pend)
    );

    tspf_vram #(
        .DEPTH (VRAM_DEPTH)
    ) u_vram (
        .clk   (clk),
        .en    (req.en),
        .we    (req.we),
        .addr  (AW'(req.addr)),
        .wdata (req.wdata),
        .rdata (rdata)
    );

    // Two-entry output queue; a palette read is issued only when its pixel is sure
    // of a place in the queue on the following cycle.
    assign pop      = m_tvalid && m_tready;
    assign issue_ok = ({1'b0, count_reg} + {2'b0, pend.valid}) <= ({2'b0, pop} + 3'd1);

    assign new_pix.pixel_x        = pend.pixel_x;
    assign new_pix.pixel_y        = pend.pixel_y;
    assign new_pix.pixel_value    = pend.pixel_value;
    assign new_pix.palette_select = pend.palette_select;
    assign new_pix.color_index    = rdata;
    assign new_pix.last           = pend.last;

    always_comb
    begin
        out_next   = out_reg;
        skid_next  = skid_reg;
        count_next = count_reg;
        case (count_reg)
            2'd0:
            begin
                if (pend.valid)
                begin
                    out_next   = new_pix;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (pend.valid && pop)
                begin
                    out_next = new_pix;
                end
                else if (pend.valid)
                begin
                    skid_next  = new_pix;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    out_next = skid_reg;
                    if (pend.valid)
                    begin
                        skid_next = new_pix;
                    end
                    else
                    begin
                        count_next = 2'd1;
                    end
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'b0, out_reg.color_index, out_reg.palette_select,
                       out_reg.pixel_value, out_reg.pixel_y, out_reg.pixel_x};

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |-> !pend.valid)
        else $error("pixel arrives at a full output queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend.valid |=> count_reg != 2'd0)
        else $error("pixel read result was not queued");

endmodule
`default_nettype wire

[tb/tile_sliver_pixel_fetch_core_tb.sv]
`timescale 1ns / 1ps
module tile_sliver_pixel_fetch_core_tb;
    import tspf_pkg::*;

    localparam int VRAM_WORDS     = 16384;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 110;

    // Mirror of the fetch unit: video memory contents, the pattern half and the
    // pixels still owed by the block, oldest first.
    class sliver_predictor;
        logic [7:0] vram [VRAM_WORDS];
        logic       pattern_half = 1'b1;
        logic [7:0] fetched_low = 8'h00;
        logic [7:0] fetched_high = 8'h00;
        logic [1:0] sliver_palette = 2'd0;
        pix_t       pending_pixels [$];
        int         pixels_checked = 0;
        int         errors = 0;

        function logic [13:0] name_addr(logic [4:0] col, logic [7:0] row);
            return NAMETABLE_BASE + 14'(col) + 14'({row[7:3], 5'b0});
        endfunction

        function logic [13:0] attr_addr(logic [4:0] col, logic [7:0] row);
            return ATTRIBUTE_BASE + 14'(col[4:2]) + 14'({row[7:5], 3'b0});
        endfunction

        // The quadrant is picked by bit 1 of the column and bit 4 of the row.
        function logic [1:0] palette_of(logic [7:0] attr, logic [4:0] col, logic [7:0] row);
            return 2'(attr >> {row[4], col[1], 1'b0});
        endfunction

        function logic [13:0] plane_addr(logic [7:0] tile, logic [7:0] row);
            return (pattern_half ? 14'h1000 : 14'h0000) + 14'({tile, 4'b0}) + 14'(row[2:0]);
        endfunction

        function void take_item(in_item_t it);
            pix_t        want;
            logic [13:0] pa;
            logic [7:0]  tile;
            if (it.op == OP_WRITE)
            begin
                vram[it.write_address] = it.write_data;
                return;
            end
            tile = vram[name_addr(it.tile_column, it.pixel_row)];
            sliver_palette = palette_of(vram[attr_addr(it.tile_column, it.pixel_row)],
                                        it.tile_column, it.pixel_row);
            pa = plane_addr(tile, it.pixel_row);
            fetched_low  = vram[pa];
            fetched_high = vram[pa + 14'd8];
            for (int i = 0; i < 8; i++)
            begin
                want.pixel_x        = {it.tile_column, 3'b000} + 8'(i);
                want.pixel_y        = it.pixel_row;
                want.pixel_value    = {fetched_high[7-i], fetched_low[7-i]};
                want.palette_select = sliver_palette;
                want.color_index    = vram[PALETTE_BASE + 14'({sliver_palette, want.pixel_value})];
                want.last           = (i == 7);
                pending_pixels.push_back(want);
            end
        endfunction

        function void check_pixel(pix_t got);
            pix_t want;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel: x %0d y %0d", got.pixel_x, got.pixel_y);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.pixel_x !== want.pixel_x)
            begin
                $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
                errors++;
            end
            if (got.pixel_y !== want.pixel_y)
            begin
                $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
                errors++;
            end
            if (got.pixel_value !== want.pixel_value)
            begin
                $error("pixel_value: expected %0d, got %0d", want.pixel_value, got.pixel_value);
                errors++;
            end
            if (got.palette_select !== want.palette_select)
            begin
                $error("palette_select: expected %0d, got %0d",
                       want.palette_select, got.palette_select);
                errors++;
            end
            if (got.color_index !== want.color_index)
            begin
                $error("color_index: expected 0x%02h, got 0x%02h",
                       want.color_index, got.color_index);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data = '0;

    sliver_predictor pred;
    bit loaded [VRAM_WORDS];
    bit source_steady = 1'b0;
    bit sink_steady = 1'b0;
    bit sink_hold = 1'b0;
    int items_sent = 0;
    int renders_sent = 0;
    int tall_rows = 0;
    int cfg_writes = 0;
    int stall_cycles = 0;

    tile_sliver_pixel_fetch_core #(
        .VRAM_DEPTH(VRAM_WORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Ends the run if nothing at all is accepted for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input logic op, input logic [13:0] addr, input logic [7:0] data,
                             input logic [4:0] col, input logic [7:0] row);
        in_item_t it;
        int       gap;
        it.op            = op;
        it.write_address = addr;
        it.write_data    = data;
        it.tile_column   = col;
        it.pixel_row     = row;
        gap = source_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {5'b00000, row, col, data, addr};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pred.take_item(it);
        items_sent++;
        if (op == OP_WRITE)
            loaded[addr] = 1'b1;
        if ($urandom_range(0, 24) == 0)
            source_steady = !source_steady;
    endtask

    // Stops offering items and waits for every owed pixel.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pred.pending_pixels.size() != 0) @(posedge clk);
    endtask

    task automatic set_pattern_half(input logic half);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= half;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        pred.pattern_half = half;
        cfg_writes++;
    endtask

    task automatic load_if_empty(input logic [13:0] addr);
        if (!loaded[addr])
            send_item(OP_WRITE, addr, 8'($urandom), 5'($urandom), 8'($urandom));
    endtask

    // Makes sure every byte the sliver reads has been written, then renders it.
    task automatic render_sliver(input logic [4:0] col, input logic [7:0] row);
        logic [13:0] nt_addr;
        logic [13:0] at_addr;
        logic [13:0] pat_addr;
        logic [1:0]  pal;
        nt_addr = pred.name_addr(col, row);
        load_if_empty(nt_addr);
        at_addr = pred.attr_addr(col, row);
        load_if_empty(at_addr);
        pal = pred.palette_of(pred.vram[at_addr], col, row);
        pat_addr = pred.plane_addr(pred.vram[nt_addr], row);
        load_if_empty(pat_addr);
        load_if_empty(pat_addr + 14'd8);
        for (int v = 0; v < 4; v++)
            load_if_empty(PALETTE_BASE + 14'({pal, 2'(v)}));
        send_item(OP_RENDER, 14'($urandom), 8'($urandom), col, row);
        renders_sent++;
        if (row > 8'd239)
            tall_rows++;
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            render_sliver(5'($urandom), ($urandom_range(0, 9) == 0) ?
                          8'($urandom_range(240, 255)) : 8'($urandom_range(0, 239)));
        else if (pick < 75)
            send_item(OP_WRITE, PALETTE_BASE + 14'($urandom_range(0, 15)), 8'($urandom),
                      5'($urandom), 8'($urandom));
        else if (pick < 85)
            send_item(OP_WRITE, NAMETABLE_BASE + 14'($urandom_range(0, 1023)), 8'($urandom),
                      5'($urandom), 8'($urandom));
        else
            send_item(OP_WRITE, 14'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
    endtask

    // Pixel sink with random back-pressure and one long hold-off on request.
    initial
    begin
        int   wait_cycles;
        pix_t got;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold)
            begin
                wait_cycles = HOLD_CYCLES;
                sink_hold = 1'b0;
            end
            else
                wait_cycles = sink_steady ? 0 : $urandom_range(0, 19);
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got.pixel_x        = m_tdata[7:0];
            got.pixel_y        = m_tdata[15:8];
            got.pixel_value    = m_tdata[17:16];
            got.palette_select = m_tdata[19:18];
            got.color_index    = m_tdata[27:20];
            got.last           = m_tlast;
            pred.check_pixel(got);
            if ($urandom_range(0, 29) == 0)
                sink_steady = !sink_steady;
        end
    end

    initial
    begin
        int  phase_start;
        bit  did_hold;
        bit  did_pause;
        pred = new();
        did_hold = 1'b0;
        did_pause = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Address and data extremes, then slivers covering three of the four quadrants,
        // the last column, the last visible row and a row past the screen.
        send_item(OP_WRITE, 14'h0000, 8'hFF, 5'd31, 8'd255);
        send_item(OP_WRITE, 14'h3FFF, 8'h00, 5'd0, 8'd0);
        send_item(OP_WRITE, NAMETABLE_BASE, 8'h00, 5'd0, 8'd0);
        send_item(OP_WRITE, ATTRIBUTE_BASE, 8'hE4, 5'd0, 8'd0);
        send_item(OP_WRITE, 14'h1000, 8'hF0, 5'd0, 8'd0);
        send_item(OP_WRITE, 14'h1008, 8'hCC, 5'd0, 8'd0);
        render_sliver(5'd0, 8'd0);
        render_sliver(5'd3, 8'd16);
        send_item(OP_WRITE, pred.name_addr(5'd31, 8'd239), 8'hFF, 5'd0, 8'd0);
        render_sliver(5'd31, 8'd239);
        render_sliver(5'd31, 8'd255);

        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase < 2)
                set_pattern_half(phase[0]);
            else
                set_pattern_half(1'($urandom));
            phase_start = items_sent;
            while (items_sent < phase_start + PHASE_ITEMS)
            begin
                if (phase == 1 && !did_hold && items_sent > phase_start + 20)
                begin
                    sink_hold = 1'b1;
                    did_hold = 1'b1;
                end
                if (phase == 2 && !did_pause && items_sent > phase_start + 30)
                begin
                    drain_results();
                    did_pause = 1'b1;
                end
                random_item();
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        $display("Sent %0d items: %0d slivers (%0d below row 239) and %0d memory writes.",
                 items_sent, renders_sent, tall_rows, items_sent - renders_sent);
        $display("Checked %0d pixels over %0d pattern half settings.",
                 pred.pixels_checked, cfg_writes);
        if (pred.errors == 0 && pred.pending_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
